/* design/rme_pkg.sv */
// Shared constants for the RSA modular exponentiation block.
// Depends on nothing; rme_if and the top level import it.
package rme_pkg;
  localparam int CHAR_WIDTH = 8;
  localparam int CFG_IDX_WIDTH = 8;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODULUS = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_EXPONENT = 8'd1;
endpackage

/* design/rme_if.sv */
// Valid/ready stream interfaces for the character input and cipher output.
// Depends on rme_pkg for the character width.
interface rme_in_if;
  import rme_pkg::*;
  logic valid;
  logic ready;
  logic [CHAR_WIDTH-1:0] message_char;
  modport source (output valid, output message_char, input ready);
  modport sink (input valid, input message_char, output ready);
endinterface

interface rme_out_if #(parameter int MOD_WIDTH = 16);
  logic valid;
  logic ready;
  logic [MOD_WIDTH-1:0] cipher_value;
  modport source (output valid, output cipher_value, input ready);
  modport sink (input valid, input cipher_value, output ready);
endinterface

/* design/rme_cell.sv */
// One shift-and-add step of a modular multiply, registered.
// Depends on nothing; instantiated in a chain by the top level.
module rme_cell #(
  parameter int MOD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [MOD_WIDTH-1:0] modulus,
  input  logic                 valid_in,
  input  logic [MOD_WIDTH-1:0] a_in,
  input  logic [MOD_WIDTH-1:0] base_in,
  input  logic [MOD_WIDTH-1:0] r_in,
  input  logic [MOD_WIDTH-1:0] b_in,
  output logic                 valid_out,
  output logic [MOD_WIDTH-1:0] a_out,
  output logic [MOD_WIDTH-1:0] base_out,
  output logic [MOD_WIDTH-1:0] r_out,
  output logic [MOD_WIDTH-1:0] b_out
);
  logic                 valid_r;
  logic [MOD_WIDTH-1:0] a_r, base_r, r_r, b_r;
  logic [MOD_WIDTH:0]   dbl, dbl_red, sum;
  logic [MOD_WIDTH-1:0] r_nxt;
  logic [MOD_WIDTH:0]   m_ext;

  always_comb begin
    m_ext = {1'b0, modulus};
    dbl = {r_in, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum = {1'b0, dbl_red[MOD_WIDTH-1:0]} + {1'b0, a_in};
    if (b_in[MOD_WIDTH-1]) begin
      r_nxt = (sum >= m_ext) ? sum[MOD_WIDTH-1:0] - modulus : sum[MOD_WIDTH-1:0];
    end else begin
      r_nxt = dbl_red[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      a_r <= a_in;
      base_r <= base_in;
      r_r <= r_nxt;
      b_r <= {b_in[MOD_WIDTH-2:0], 1'b0};
    end
  end

  assign valid_out = valid_r;
  assign a_out = a_r;
  assign base_out = base_r;
  assign r_out = r_r;
  assign b_out = b_r;
endmodule

/* design/rsa_modular_exponentiation.sv */
// Top level: character in, c^e mod n out, through a chain of multiply cells.
// Depends on rme_pkg, rme_if and rme_cell.
//
//   channel | dir | payload                   | handshake
//   in_ch   | in  | message_char [7:0]        | valid/ready
//   out_ch  | out | cipher_value [MOD_WIDTH]  | valid/ready
//   cfg     | in  | cfg_index, cfg_wdata      | cfg_we, no wait
//
// The result passes through a chain of registered cells, one cell per multiply bit.
// One transfer is accepted every cycle while the output side takes results.
// The whole chain advances together; an output stall holds every cell.
// Reset clears the valid bits and loads modulus 2 and exponent 1.
module rsa_modular_exponentiation #(
  parameter int MOD_WIDTH = 16,
  parameter int EXP_WIDTH = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rme_in_if.sink                    in_ch,
  rme_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [rme_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [((MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH)-1:0] cfg_wdata
);
  import rme_pkg::*;

  localparam int NMUL = 2 * EXP_WIDTH + 1;
  localparam int NCELL = NMUL * MOD_WIDTH;

  logic [MOD_WIDTH-1:0] modulus_r;
  logic [EXP_WIDTH-1:0] exponent_r;
  logic                 en;
  logic [MOD_WIDTH-1:0] one_mod;

  logic                 v_o [NCELL];
  logic [MOD_WIDTH-1:0] a_o [NCELL];
  logic [MOD_WIDTH-1:0] s_o [NCELL];
  logic [MOD_WIDTH-1:0] r_o [NCELL];
  logic [MOD_WIDTH-1:0] b_o [NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_WIDTH'(2);
      exponent_r <= EXP_WIDTH'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODULUS) begin
        modulus_r <= cfg_wdata[MOD_WIDTH-1:0];
      end else if (cfg_index == CFG_EXPONENT) begin
        exponent_r <= cfg_wdata[EXP_WIDTH-1:0];
      end
    end
  end

  assign en = out_ch.ready || !v_o[NCELL-1];
  assign in_ch.ready = en;
  assign one_mod = (modulus_r == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      logic                 vi;
      logic [MOD_WIDTH-1:0] ai, si, ri, bi;
      if (g == 0) begin : g_first
        assign vi = in_ch.valid;
        assign ai = one_mod;
        assign si = '0;
        assign ri = '0;
        assign bi = MOD_WIDTH'(in_ch.message_char);
      end else if (g == MOD_WIDTH) begin : g_start
        assign vi = v_o[g-1];
        assign ai = one_mod;
        assign si = r_o[g-1];
        assign ri = '0;
        assign bi = one_mod;
      end else if ((g % MOD_WIDTH) == 0 && ((g / MOD_WIDTH) % 2) == 1) begin : g_sq
        assign vi = v_o[g-1];
        assign ai = r_o[g-1];
        assign si = s_o[g-1];
        assign ri = '0;
        assign bi = r_o[g-1];
      end else if ((g % MOD_WIDTH) == 0) begin : g_mul
        assign vi = v_o[g-1];
        assign ai = r_o[g-1];
        assign si = s_o[g-1];
        assign ri = '0;
        assign bi = exponent_r[EXP_WIDTH - (g / MOD_WIDTH) / 2] ? s_o[g-1] : MOD_WIDTH'(1);
      end else begin : g_mid
        assign vi = v_o[g-1];
        assign ai = a_o[g-1];
        assign si = s_o[g-1];
        assign ri = r_o[g-1];
        assign bi = b_o[g-1];
      end
      rme_cell #(.MOD_WIDTH(MOD_WIDTH)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(en), .modulus(modulus_r),
        .valid_in(vi), .a_in(ai), .base_in(si), .r_in(ri), .b_in(bi),
        .valid_out(v_o[g]), .a_out(a_o[g]), .base_out(s_o[g]),
        .r_out(r_o[g]), .b_out(b_o[g])
      );
    end
  endgenerate

  assign out_ch.valid = v_o[NCELL-1];
  assign out_ch.cipher_value = (modulus_r == '0) ? '0 : r_o[NCELL-1];
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the RSA modular exponentiation block.
// Depends on rme_pkg, rme_if and the rsa_modular_exponentiation top level.
module tb_top;
  import rme_pkg::*;

  localparam int MOD_WIDTH = 16;
  localparam int EXP_WIDTH = 8;
  localparam int CFG_WIDTH = (MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH;
  localparam int LATENCY = (2 * EXP_WIDTH + 1) * MOD_WIDTH;
  localparam int RANDOM_ITEMS = 1800;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INDEX_BAD = 8'd7;

  typedef struct {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  has_exp;
    logic [MOD_WIDTH-1:0]  exp_value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;

  rme_in_if in_ch ();
  rme_out_if #(.MOD_WIDTH(MOD_WIDTH)) out_ch ();

  rsa_modular_exponentiation #(.MOD_WIDTH(MOD_WIDTH), .EXP_WIDTH(EXP_WIDTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [MOD_WIDTH-1:0] cur_modulus;
  logic [EXP_WIDTH-1:0] cur_exponent;
  logic [MOD_WIDTH-1:0] cipher_queue[$];
  int mismatches = 0;
  int stall_mode = 0;

  function automatic logic [MOD_WIDTH-1:0] mulmod(logic [MOD_WIDTH-1:0] a,
                                                  logic [MOD_WIDTH-1:0] b,
                                                  logic [MOD_WIDTH-1:0] m);
    logic [2*MOD_WIDTH-1:0] prod;
    prod = a * b;
    return MOD_WIDTH'(prod % m);
  endfunction

  function automatic logic [MOD_WIDTH-1:0] encrypt(logic [CHAR_WIDTH-1:0] ch);
    logic [MOD_WIDTH-1:0] base;
    logic [MOD_WIDTH-1:0] acc;
    if (cur_modulus == 0) return '0;
    base = ch % cur_modulus;
    acc = (cur_modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
    for (int i = EXP_WIDTH - 1; i >= 0; i--) begin
      acc = mulmod(acc, acc, cur_modulus);
      if (cur_exponent[i]) acc = mulmod(acc, base, cur_modulus);
    end
    return acc;
  endfunction

  task automatic report(string what, logic [MOD_WIDTH-1:0] got, logic [MOD_WIDTH-1:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODULUS) cur_modulus = value[MOD_WIDTH-1:0];
    else if (idx == CFG_EXPONENT) cur_exponent = value[EXP_WIDTH-1:0];
    @(posedge clk);
  endtask

  task automatic send(logic [CHAR_WIDTH-1:0] ch, logic has_exp, logic [MOD_WIDTH-1:0] value);
    in_ch.valid <= 1'b1;
    in_ch.message_char <= ch;
    do @(posedge clk); while (!in_ch.ready);
    cipher_queue.push_back(has_exp ? value : encrypt(ch));
  endtask

  task automatic send_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && count > 0) begin
        send(CHAR_WIDTH'($urandom_range(0, 255)), 1'b0, '0);
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (cipher_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (cipher_queue.size() != 0) begin
      report("missing cipher_value", '0, cipher_queue[0]);
      cipher_queue.delete();
    end
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cipher_queue.size() == 0) report("unexpected cipher_value", out_ch.cipher_value, '0);
      else begin
        logic [MOD_WIDTH-1:0] want;
        want = cipher_queue.pop_front();
        if (out_ch.cipher_value !== want) report("cipher_value", out_ch.cipher_value, want);
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 2);
  end

  stim_row_t directed[] = '{
    '{8'd0, 1'b1, 16'd0}, '{8'd1, 1'b1, 16'd1}, '{8'd2, 1'b1, 16'd0},
    '{8'd255, 1'b1, 16'd1}, '{8'd254, 1'b1, 16'd0}, '{8'd127, 1'b0, 16'd0},
    '{8'd128, 1'b0, 16'd0}, '{8'd85, 1'b0, 16'd0}, '{8'd170, 1'b0, 16'd0}
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.message_char = '0;
    cur_modulus = MOD_WIDTH'(2);
    cur_exponent = EXP_WIDTH'(1);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send(directed[i].ch, directed[i].has_exp, directed[i].exp_value);
    drain();

    write_reg(CFG_EXPONENT, CFG_WIDTH'(0));
    send(8'd0, 1'b1, 16'd1);
    send(8'd200, 1'b1, 16'd1);
    drain();
    write_reg(CFG_MODULUS, CFG_WIDTH'(0));
    write_reg(CFG_EXPONENT, CFG_WIDTH'(255));
    send(8'd255, 1'b1, 16'd0);
    send(8'd7, 1'b1, 16'd0);
    drain();
    write_reg(CFG_MODULUS, CFG_WIDTH'(1));
    send(8'd200, 1'b1, 16'd0);
    drain();
    write_reg(CFG_MODULUS, 16'hFFFF);
    write_reg(CFG_INDEX_BAD, 16'h1234);
    send(8'd255, 1'b0, '0);
    send(8'd3, 1'b0, '0);
    drain();
    write_reg(CFG_EXPONENT, 16'hFF03);
    send(8'd255, 1'b0, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MODULUS, CFG_WIDTH'(3233));
          write_reg(CFG_EXPONENT, CFG_WIDTH'(17));
        end
        1: begin
          write_reg(CFG_MODULUS, CFG_WIDTH'($urandom_range(2, 300)));
          write_reg(CFG_EXPONENT, CFG_WIDTH'($urandom_range(0, 255)));
        end
        2: begin
          write_reg(CFG_MODULUS, CFG_WIDTH'($urandom_range(256, 65535)));
          write_reg(CFG_EXPONENT, CFG_WIDTH'(255));
        end
        3: begin
          write_reg(CFG_MODULUS, CFG_WIDTH'(65535));
          write_reg(CFG_EXPONENT, CFG_WIDTH'($urandom_range(0, 255)));
        end
        4: begin
          write_reg(CFG_MODULUS, CFG_WIDTH'($urandom));
          write_reg(CFG_EXPONENT, CFG_WIDTH'($urandom));
        end
        default: begin
          write_reg(CFG_MODULUS, CFG_WIDTH'(2));
          write_reg(CFG_EXPONENT, CFG_WIDTH'(1));
        end
      endcase
      send_random(RANDOM_ITEMS / 6);
      drain();
    end

    if (mismatches == 0) $display("rsa_modular_exponentiation test passed");
    else $display("rsa_modular_exponentiation test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("rsa_modular_exponentiation test failed");
    $finish;
  end
endmodule
